// ===== src/esc_pkg.sv =====
`default_nettype none

package esc_pkg;

    localparam int FLOOR_W  = 8;
    localparam int STATUS_W = 2;
    localparam int MOTION_W = 2;

    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    typedef enum logic [MOTION_W-1:0] {
        MOT_IDLE = 2'd0,
        MOT_UP   = 2'd1,
        MOT_DOWN = 2'd2
    } motion_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAME  = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_READ,
        S_EXEC,
        S_FINISH,
        S_OUTPUT
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic setup;
        logic read;
        logic exec;
        logic finish;
        logic load;
    } esc_cmd_t;

    typedef struct packed {
        logic reject;
        logic pass_end;
        logic out_busy;
    } esc_stat_t;

endpackage

`default_nettype wire

// ===== src/esc_req_if.sv =====
`default_nettype none

interface esc_req_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [esc_pkg::FLOOR_W-1:0] entry_floor;
    logic [esc_pkg::FLOOR_W-1:0] exit_floor;

    modport source (output valid, output mode, output entry_floor, output exit_floor,
                    input ready);
    modport sink   (input valid, input mode, input entry_floor, input exit_floor,
                    output ready);
endinterface

`default_nettype wire

// ===== src/esc_rsp_if.sv =====
`default_nettype none

interface esc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [esc_pkg::STATUS_W-1:0] status;
    logic [esc_pkg::FLOOR_W-1:0]  car_floor;
    logic [esc_pkg::MOTION_W-1:0] direction;
    logic [esc_pkg::FLOOR_W-1:0]  top_target;
    logic [esc_pkg::FLOOR_W-1:0]  bottom_target;

    modport source (output valid, output status, output car_floor, output direction,
                    output top_target, output bottom_target, input ready);
    modport sink   (input valid, input status, input car_floor, input direction,
                    input top_target, input bottom_target, output ready);
endinterface

`default_nettype wire

// ===== src/esc_ram.sv =====
`default_nettype none

module esc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/esc_ctrl.sv =====
`default_nettype none

module esc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire esc_pkg::esc_stat_t stat,
    output esc_pkg::esc_cmd_t       cmd
);

    esc_pkg::ctrl_state_t state_reg;
    esc_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= esc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            esc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = esc_pkg::S_SETUP;
                end
            end
            esc_pkg::S_SETUP:
            begin
                state_next = stat.reject ? esc_pkg::S_OUTPUT : esc_pkg::S_READ;
            end
            esc_pkg::S_READ:
            begin
                state_next = esc_pkg::S_EXEC;
            end
            esc_pkg::S_EXEC:
            begin
                state_next = stat.pass_end ? esc_pkg::S_FINISH : esc_pkg::S_READ;
            end
            esc_pkg::S_FINISH:
            begin
                state_next = esc_pkg::S_OUTPUT;
            end
            esc_pkg::S_OUTPUT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = esc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = esc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            esc_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            esc_pkg::S_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            esc_pkg::S_READ:
            begin
                cmd.read = 1'b1;
            end
            esc_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            esc_pkg::S_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            esc_pkg::S_OUTPUT:
            begin
                cmd.load = !stat.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/esc_datapath.sv =====
`default_nettype none

module esc_datapath #(
    parameter int FLOORS = 16,
    parameter int RIDERS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire esc_pkg::esc_cmd_t             cmd,
    output esc_pkg::esc_stat_t                 stat,
    input  wire logic                          in_mode,
    input  wire logic [esc_pkg::FLOOR_W-1:0]   in_entry,
    input  wire logic [esc_pkg::FLOOR_W-1:0]   in_exit,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [esc_pkg::STATUS_W-1:0]       out_status,
    output logic [esc_pkg::FLOOR_W-1:0]        out_car,
    output logic [esc_pkg::MOTION_W-1:0]       out_direction,
    output logic [esc_pkg::FLOOR_W-1:0]        out_top,
    output logic [esc_pkg::FLOOR_W-1:0]        out_bottom
);

    localparam int IDX_W  = (RIDERS > 1) ? $clog2(RIDERS) : 1;
    localparam int SLOT_W = 2 * esc_pkg::FLOOR_W;
    localparam logic [esc_pkg::FLOOR_W-1:0] TOP_FLOOR = esc_pkg::FLOOR_W'(FLOORS);
    localparam logic [IDX_W-1:0]            LAST_IDX  = IDX_W'(RIDERS - 1);

    typedef logic [esc_pkg::FLOOR_W-1:0] floor_t;

    // control and state registers
    logic [IDX_W-1:0]   idx_reg,       idx_next;
    esc_pkg::status_t   status_reg,    status_next;
    logic               found_reg,     found_next;
    floor_t             car_reg,       car_next;
    floor_t             upper_reg,     upper_next;
    floor_t             lower_reg,     lower_next;
    esc_pkg::motion_t   motion_reg,    motion_next;
    logic [RIDERS-1:0]  valid_reg,     valid_next;
    logic [RIDERS-1:0]  aboard_reg,    aboard_next;
    logic               out_valid_reg, out_valid_next;

    // payload registers
    logic               mode_reg,      mode_next;
    floor_t             entry_reg,     entry_next;
    floor_t             exit_reg,      exit_next;
    floor_t             last_reg,      last_next;
    esc_pkg::status_t   ostatus_reg,   ostatus_next;
    floor_t             ocar_reg,      ocar_next;
    esc_pkg::motion_t   omotion_reg,   omotion_next;
    floor_t             otop_reg,      otop_next;
    floor_t             obottom_reg,   obottom_next;

    logic               ram_we;
    logic [SLOT_W-1:0]  ram_wdata;
    logic [SLOT_W-1:0]  ram_rdata;

    esc_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (RIDERS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (cmd.read),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    floor_t           b_old, d_old, b_srv, d_srv, f_old, f_new, f_scan;
    logic             a_old, a_srv;
    logic             is_tick, slot_free;
    esc_pkg::status_t in_status;
    floor_t           bound_max, bound_min;

    always_comb
    begin
        b_old = valid_reg[idx_reg] ? ram_rdata[SLOT_W-1:esc_pkg::FLOOR_W] : '0;
        d_old = valid_reg[idx_reg] ? ram_rdata[esc_pkg::FLOOR_W-1:0] : '0;
        a_old = aboard_reg[idx_reg];
        b_srv = b_old;
        d_srv = d_old;
        a_srv = a_old;
        // board, then drop
        if (b_srv == car_reg && !a_srv)
        begin
            b_srv = '0;
            a_srv = 1'b1;
        end
        if (d_srv == car_reg && a_srv)
        begin
            d_srv = '0;
            a_srv = 1'b0;
        end
        f_old  = a_old ? d_old : b_old;
        f_new  = a_srv ? d_srv : b_srv;
        f_scan = (motion_reg == esc_pkg::MOT_IDLE) ? f_old : f_new;
    end

    always_comb
    begin
        if (in_mode == esc_pkg::MODE_TICK)
        begin
            in_status = esc_pkg::ST_OK;
        end
        else if (in_entry == '0 || in_entry > TOP_FLOOR
                 || in_exit == '0 || in_exit > TOP_FLOOR)
        begin
            in_status = esc_pkg::ST_RANGE;
        end
        else if (in_entry == in_exit)
        begin
            in_status = esc_pkg::ST_SAME;
        end
        else
        begin
            in_status = esc_pkg::ST_OK;
        end
    end

    assign is_tick   = (mode_reg == esc_pkg::MODE_TICK);
    assign slot_free = (b_old == '0) && (d_old == '0);
    assign bound_max = (upper_reg > last_reg) ? upper_reg : last_reg;
    assign bound_min = (lower_reg < last_reg) ? lower_reg : last_reg;

    assign stat.reject   = (status_reg != esc_pkg::ST_OK);
    assign stat.pass_end = (idx_reg == LAST_IDX) || (!is_tick && slot_free);
    assign stat.out_busy = out_valid_reg && !out_ready;

    always_comb
    begin
        idx_next       = idx_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        car_next       = car_reg;
        upper_next     = upper_reg;
        lower_next     = lower_reg;
        motion_next    = motion_reg;
        valid_next     = valid_reg;
        aboard_next    = aboard_reg;
        out_valid_next = out_valid_reg;
        mode_next      = mode_reg;
        entry_next     = entry_reg;
        exit_next      = exit_reg;
        last_next      = last_reg;
        ostatus_next   = ostatus_reg;
        ocar_next      = ocar_reg;
        omotion_next   = omotion_reg;
        otop_next      = otop_reg;
        obottom_next   = obottom_reg;
        ram_we         = 1'b0;
        ram_wdata      = {b_srv, d_srv};

        if (cmd.capture)
        begin
            mode_next   = in_mode;
            entry_next  = in_entry;
            exit_next   = in_exit;
            status_next = in_status;
            idx_next    = '0;
            found_next  = 1'b0;
        end

        if (cmd.setup && is_tick)
        begin
            case (motion_reg)
                esc_pkg::MOT_IDLE:
                begin
                    upper_next = car_reg;
                    lower_next = car_reg;
                end
                esc_pkg::MOT_UP:
                begin
                    car_next   = (car_reg < upper_reg) ? car_reg + 1'b1 : car_reg;
                    last_next  = upper_reg;
                    upper_next = '0;
                    lower_next = car_next;
                end
                esc_pkg::MOT_DOWN:
                begin
                    car_next   = (car_reg > lower_reg) ? car_reg - 1'b1 : car_reg;
                    last_next  = lower_reg;
                    upper_next = '0;
                    lower_next = car_next;
                end
                default:
                begin
                    car_next = car_reg;
                end
            endcase
        end

        if (cmd.exec)
        begin
            idx_next = idx_reg + 1'b1;
            if (is_tick)
            begin
                if (f_scan > upper_reg)
                begin
                    upper_next = f_scan;
                end
                if (f_scan != '0 && f_scan < lower_reg)
                begin
                    lower_next = f_scan;
                end
                ram_we               = 1'b1;
                valid_next[idx_reg]  = 1'b1;
                aboard_next[idx_reg] = a_srv;
            end
            else if (slot_free)
            begin
                ram_we              = 1'b1;
                ram_wdata           = {entry_reg, exit_reg};
                valid_next[idx_reg] = 1'b1;
                found_next          = 1'b1;
            end
        end

        if (cmd.finish)
        begin
            if (!is_tick)
            begin
                status_next = found_reg ? esc_pkg::ST_OK : esc_pkg::ST_FULL;
            end
            else
            begin
                case (motion_reg)
                    esc_pkg::MOT_IDLE:
                    begin
                        if (upper_reg > car_reg)
                        begin
                            motion_next = esc_pkg::MOT_UP;
                        end
                        else if (lower_reg != '0 && lower_reg < car_reg)
                        begin
                            motion_next = esc_pkg::MOT_DOWN;
                        end
                    end
                    esc_pkg::MOT_UP:
                    begin
                        if (car_reg == bound_max)
                        begin
                            upper_next  = car_reg;
                            motion_next = (lower_reg < car_reg) ? esc_pkg::MOT_DOWN
                                                                : esc_pkg::MOT_IDLE;
                        end
                    end
                    esc_pkg::MOT_DOWN:
                    begin
                        if (car_reg == bound_min)
                        begin
                            lower_next = car_reg;
                            if (upper_reg > car_reg)
                            begin
                                motion_next = esc_pkg::MOT_UP;
                            end
                            else
                            begin
                                upper_next  = car_reg;
                                motion_next = esc_pkg::MOT_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                        motion_next = motion_reg;
                    end
                endcase
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
            ostatus_next   = status_reg;
            ocar_next      = car_reg;
            omotion_next   = motion_reg;
            otop_next      = upper_reg;
            obottom_next   = lower_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            status_reg    <= esc_pkg::ST_OK;
            found_reg     <= 1'b0;
            car_reg       <= esc_pkg::FLOOR_W'(1);
            upper_reg     <= esc_pkg::FLOOR_W'(1);
            lower_reg     <= esc_pkg::FLOOR_W'(1);
            motion_reg    <= esc_pkg::MOT_IDLE;
            valid_reg     <= '0;
            aboard_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            status_reg    <= status_next;
            found_reg     <= found_next;
            car_reg       <= car_next;
            upper_reg     <= upper_next;
            lower_reg     <= lower_next;
            motion_reg    <= motion_next;
            valid_reg     <= valid_next;
            aboard_reg    <= aboard_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        entry_reg   <= entry_next;
        exit_reg    <= exit_next;
        last_reg    <= last_next;
        ostatus_reg <= ostatus_next;
        ocar_reg    <= ocar_next;
        omotion_reg <= omotion_next;
        otop_reg    <= otop_next;
        obottom_reg <= obottom_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_status    = ostatus_reg;
    assign out_car       = ocar_reg;
    assign out_direction = omotion_reg;
    assign out_top       = otop_reg;
    assign out_bottom    = obottom_reg;

endmodule

`default_nettype wire

// ===== src/elevator_scan_controller.sv =====
`default_nettype none

// Channel  Dir  Handshake    Payload
// req      in   valid/ready  mode, entry_floor, exit_floor
// rsp      out  valid/ready  status, car_floor, direction, top_target, bottom_target
//
// A tick reads and updates every one of the RIDERS slots; a request rejected on its floors
// goes from setup straight to output, else it searches slots up to the first free one.
// Each slot is read from the registered-read slot RAM in READ and written back in EXEC.
// Reset clears control state; per-slot valid bits make the slot table read as empty.
// A result waits in the output register while the next item is taken; an item that
// finishes while a result is still held stalls until that transfer.

module elevator_scan_controller #(
    parameter int FLOORS = 16,
    parameter int RIDERS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    esc_req_if.sink    req,
    esc_rsp_if.source  rsp
);

    esc_pkg::esc_cmd_t  cmd;
    esc_pkg::esc_stat_t stat;
    logic               in_ready;

    esc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    esc_datapath #(
        .FLOORS (FLOORS),
        .RIDERS (RIDERS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_mode       (req.mode),
        .in_entry      (req.entry_floor),
        .in_exit       (req.exit_floor),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .out_status    (rsp.status),
        .out_car       (rsp.car_floor),
        .out_direction (rsp.direction),
        .out_top       (rsp.top_target),
        .out_bottom    (rsp.bottom_target)
    );

    assign req.ready = in_ready;

endmodule

`default_nettype wire

// ===== tb/sv/elevator_scan_controller_test.sv =====
`default_nettype none

module elevator_scan_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FLOORS     = 16;
    localparam int RIDERS     = 16;
    localparam int RANDOM_REQ = 1000;
    localparam int MAX_PRINTS = 100;

    typedef struct {
        logic                        mode;
        logic [esc_pkg::FLOOR_W-1:0] entry_floor;
        logic [esc_pkg::FLOOR_W-1:0] exit_floor;
        bit                          hold;
    } floor_req_t;

    typedef struct {
        esc_pkg::status_t            status;
        logic [esc_pkg::FLOOR_W-1:0] car_floor;
        esc_pkg::motion_t            direction;
        logic [esc_pkg::FLOOR_W-1:0] top_target;
        logic [esc_pkg::FLOOR_W-1:0] bottom_target;
    } car_view_t;

    logic clk;
    logic rst_n;

    esc_req_if req_ch ();
    esc_rsp_if rsp_ch ();

    elevator_scan_controller #(
        .FLOORS(FLOORS),
        .RIDERS(RIDERS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    floor_req_t pending_reqs[$];
    car_view_t  expected_views[$];
    floor_req_t on_wire;
    int         n_taken;
    int         total_items;
    int         errors;
    wire        calm = (n_taken >= 400) && (n_taken < 600);

    logic [esc_pkg::FLOOR_W-1:0] car_pos;
    logic [esc_pkg::FLOOR_W-1:0] upper;
    logic [esc_pkg::FLOOR_W-1:0] lower;
    esc_pkg::motion_t            motion;
    logic [esc_pkg::FLOOR_W-1:0] boarding[RIDERS];
    logic [esc_pkg::FLOOR_W-1:0] destination[RIDERS];
    logic                        aboard[RIDERS];

    function automatic void serve_current_floor();
        for (int i = 0; i < RIDERS; i++)
        begin
            if (boarding[i] == car_pos && !aboard[i])
            begin
                boarding[i] = '0;
                aboard[i]   = 1'b1;
            end
            if (destination[i] == car_pos && aboard[i])
            begin
                destination[i] = '0;
                aboard[i]      = 1'b0;
            end
        end
    endfunction

    function automatic void widen_targets();
        logic [esc_pkg::FLOOR_W-1:0] f;
        for (int i = 0; i < RIDERS; i++)
        begin
            f = aboard[i] ? destination[i] : boarding[i];
            if (f > upper)
                upper = f;
            if (f != 0 && f < lower)
                lower = f;
        end
    endfunction

    function automatic car_view_t predict_car_view(floor_req_t item);
        car_view_t                   view;
        logic [esc_pkg::FLOOR_W-1:0] last;
        view.status = esc_pkg::ST_OK;
        if (item.mode == esc_pkg::MODE_TICK)
        begin
            case (motion)
                esc_pkg::MOT_IDLE:
                begin
                    upper = car_pos;
                    lower = car_pos;
                    widen_targets();
                    if (upper > car_pos)
                        motion = esc_pkg::MOT_UP;
                    else if (lower != 0 && lower < car_pos)
                        motion = esc_pkg::MOT_DOWN;
                    serve_current_floor();
                end
                esc_pkg::MOT_UP:
                begin
                    if (car_pos < upper)
                        car_pos = car_pos + 1'b1;
                    serve_current_floor();
                    last  = upper;
                    upper = '0;
                    lower = car_pos;
                    widen_targets();
                    if (upper > last)
                        last = upper;
                    if (car_pos == last)
                    begin
                        upper = car_pos;
                        if (lower < car_pos)
                            motion = esc_pkg::MOT_DOWN;
                        else
                            motion = esc_pkg::MOT_IDLE;
                    end
                end
                esc_pkg::MOT_DOWN:
                begin
                    if (car_pos > lower)
                        car_pos = car_pos - 1'b1;
                    serve_current_floor();
                    last  = lower;
                    upper = '0;
                    lower = car_pos;
                    widen_targets();
                    if (lower < last)
                        last = lower;
                    if (car_pos == last)
                    begin
                        lower = car_pos;
                        if (upper > car_pos)
                            motion = esc_pkg::MOT_UP;
                        else
                        begin
                            upper  = car_pos;
                            motion = esc_pkg::MOT_IDLE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (item.entry_floor == 0 || item.entry_floor > FLOORS ||
                 item.exit_floor == 0 || item.exit_floor > FLOORS)
            view.status = esc_pkg::ST_RANGE;
        else if (item.entry_floor == item.exit_floor)
            view.status = esc_pkg::ST_SAME;
        else
        begin
            view.status = esc_pkg::ST_FULL;
            for (int i = 0; i < RIDERS; i++)
            begin
                if (view.status == esc_pkg::ST_FULL && boarding[i] == 0 &&
                    destination[i] == 0)
                begin
                    boarding[i]    = item.entry_floor;
                    destination[i] = item.exit_floor;
                    view.status    = esc_pkg::ST_OK;
                end
            end
        end
        view.car_floor     = car_pos;
        view.direction     = motion;
        view.top_target    = upper;
        view.bottom_target = lower;
        return view;
    endfunction

    task automatic report_mismatch(string what);
        if (errors < MAX_PRINTS)
            $display("ERROR %0t ns: %s", $time, what);
        errors++;
    endtask

    task automatic push_req(logic mode, int entry_floor, int exit_floor, bit hold);
        floor_req_t item;
        item.mode        = mode;
        item.entry_floor = entry_floor[esc_pkg::FLOOR_W-1:0];
        item.exit_floor  = exit_floor[esc_pkg::FLOOR_W-1:0];
        item.hold        = hold;
        pending_reqs.push_back(item);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.mode        <= esc_pkg::MODE_REQUEST;
            req_ch.entry_floor <= '0;
            req_ch.exit_floor  <= '0;
            n_taken            <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_views.push_back(predict_car_view(on_wire));
                n_taken <= n_taken + 1;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                // hold a marked item until the car has answered everything before it
                if (pending_reqs.size() != 0 &&
                    (!pending_reqs[0].hold || expected_views.size() == 0) &&
                    (calm || $urandom_range(99) >= 15))
                begin
                    on_wire = pending_reqs.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.mode        <= on_wire.mode;
                    req_ch.entry_floor <= on_wire.entry_floor;
                    req_ch.exit_floor  <= on_wire.exit_floor;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        car_view_t seen;
        car_view_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                seen.status        = esc_pkg::status_t'(rsp_ch.status);
                seen.car_floor     = rsp_ch.car_floor;
                seen.direction     = esc_pkg::motion_t'(rsp_ch.direction);
                seen.top_target    = rsp_ch.top_target;
                seen.bottom_target = rsp_ch.bottom_target;
                if (expected_views.size() == 0)
                    report_mismatch($sformatf("unexpected transfer st=%0d car=%0d dir=%0d",
                                              seen.status, seen.car_floor, seen.direction));
                else
                begin
                    want = expected_views.pop_front();
                    if (seen.status !== want.status || seen.car_floor !== want.car_floor ||
                        seen.direction !== want.direction ||
                        seen.top_target !== want.top_target ||
                        seen.bottom_target !== want.bottom_target)
                        report_mismatch($sformatf(
                            "got st/car/dir/top/bot %0d/%0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d/%0d",
                            seen.status, seen.car_floor, seen.direction, seen.top_target,
                            seen.bottom_target, want.status, want.car_floor, want.direction,
                            want.top_target, want.bottom_target));
                end
            end
            rsp_ch.ready <= calm || ($urandom_range(99) >= 15);
        end
    end

    initial
    begin
        int   pick;
        int   entry_floor;
        int   exit_floor;
        int   spins;
        rst_n              = 1'b0;
        errors             = 0;
        car_pos            = 1;
        upper              = 1;
        lower              = 1;
        motion             = esc_pkg::MOT_IDLE;
        for (int i = 0; i < RIDERS; i++)
        begin
            boarding[i]    = '0;
            destination[i] = '0;
            aboard[i]      = 1'b0;
        end

        push_req(esc_pkg::MODE_TICK, 0, 0, 0);
        push_req(esc_pkg::MODE_REQUEST, 0, 5, 0);
        push_req(esc_pkg::MODE_REQUEST, 5, 0, 0);
        push_req(esc_pkg::MODE_REQUEST, FLOORS + 1, 3, 0);
        push_req(esc_pkg::MODE_REQUEST, 255, 255, 0);
        push_req(esc_pkg::MODE_REQUEST, 3, 3, 0);
        push_req(esc_pkg::MODE_REQUEST, FLOORS, 1, 1);
        push_req(esc_pkg::MODE_REQUEST, 1, FLOORS, 0);
        for (int i = 0; i < RIDERS - 2; i++)
        begin
            entry_floor = $urandom_range(FLOORS, 1);
            exit_floor  = $urandom_range(FLOORS - 1, 1);
            if (exit_floor >= entry_floor)
                exit_floor++;
            push_req(esc_pkg::MODE_REQUEST, entry_floor, exit_floor, 0);
        end
        push_req(esc_pkg::MODE_REQUEST, 7, 9, 0);
        push_req(esc_pkg::MODE_TICK, 0, 0, 0);
        push_req(esc_pkg::MODE_TICK, 0, 0, 0);

        for (int n = 0; n < RANDOM_REQ; n++)
        begin
            pick        = $urandom_range(99);
            entry_floor = $urandom_range(FLOORS, 1);
            exit_floor  = $urandom_range(FLOORS - 1, 1);
            if (exit_floor >= entry_floor)
                exit_floor++;
            if (pick < 8)
            begin
                entry_floor = $urandom_range(255);
                exit_floor  = $urandom_range(255);
            end
            else if (pick < 11)
                exit_floor = entry_floor;
            push_req(pick < 40 ? esc_pkg::MODE_REQUEST : esc_pkg::MODE_TICK,
                     pick < 40 ? entry_floor : $urandom_range(255),
                     pick < 40 ? exit_floor : $urandom_range(255),
                     (n % 250) == 125);
        end
        total_items = pending_reqs.size();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (n_taken == total_items);
        spins = 0;
        while (expected_views.size() != 0 && spins < 50_000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (80) @(posedge clk);
        if (expected_views.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_views.size()));

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ===== elevator_scan_controller.f =====
src/esc_pkg.sv
src/esc_req_if.sv
src/esc_rsp_if.sv
src/esc_ram.sv
src/esc_ctrl.sv
src/esc_datapath.sv
src/elevator_scan_controller.sv
tb/sv/elevator_scan_controller_test.sv
